// ===== sv/q4d_pkg.sv =====
// q4d_pkg: shared types and constants for the q4 block dequantiser
// no dependencies
package q4d_pkg;

    localparam int unsigned BLOCK_BYTES = 18;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [31:0] INF_BITS = 32'h7F80_0000;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       start_of_tensor;
    } in_word_t;

    typedef struct packed {
        logic [31:0] weight_bits;
        logic        last_of_byte;
    } out_word_t;

endpackage

// ===== sv/q4d_scale_mul.sv =====
// q4d_scale_mul: exact product (nibble - 8) * half scale as single bits
// depends on q4d_pkg
module q4d_scale_mul (
    input  logic [15:0] scale,
    input  logic [3:0]  nibble,
    output logic [31:0] weight_bits
);
    import q4d_pkg::*;

    logic        hsign;
    logic [4:0]  hexp;
    logic [9:0]  hman;
    logic        nsign;
    logic [3:0]  mag;
    logic [10:0] sig;
    logic [14:0] prod;
    logic [3:0]  msb;
    logic [7:0]  bexp;
    logic [22:0] frac;
    logic [5:0]  ebase;

    always_comb
    begin
        hsign = scale[15];
        hexp  = scale[14:10];
        hman  = scale[9:0];
        nsign = ~nibble[3];
        mag   = nibble[3] ? {1'b0, nibble[2:0]} : 4'd8 - {1'b0, nibble[2:0]};
        sig   = (hexp == 5'd0) ? {1'b0, hman} : {1'b1, hman};
        ebase = (hexp == 5'd0) ? 6'd1 : {1'b0, hexp};
        prod  = sig * {7'd0, mag};
        msb   = 4'd0;
        for (int i = 0; i < 15; i++)
        begin
            if (prod[i])
            begin
                msb = 4'(i);
            end
        end
        // bias 127 - 25 = 102
        bexp  = 8'(ebase) + 8'(msb) + 8'd102;
        frac  = 23'({8'd0, prod} << (5'd23 - 5'(msb)));
        if (hexp == 5'h1F)
        begin
            weight_bits = (hman != 10'd0 || mag == 4'd0) ? QNAN_BITS
                        : ({hsign ^ nsign, 31'd0} | INF_BITS);
        end
        else if (prod == 15'd0)
        begin
            weight_bits = {hsign ^ nsign, 31'd0};
        end
        else
        begin
            weight_bits = {hsign ^ nsign, bexp, frac};
        end
    end

endmodule

// ===== sv/q4_block_dequantizer.sv =====
// q4_block_dequantizer: streams q4 blocks (half scale + 16 nibble bytes) into floats
// a data byte's low and high weights are registered into slots a and b on acceptance; a is shown first, then b
// a new data byte waits until slot b is free, set by the single result port; scale bytes 1/cycle while in_ready is high
// reset: rst_n async, clears counters, scale and weight_count to zero
// depends on q4d_pkg, q4d_scale_mul
module q4_block_dequantizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  q4d_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output q4d_pkg::out_word_t out_data,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata
);
    import q4d_pkg::*;

    logic [31:0] weight_count_reg;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  scale_lo_reg;
    logic [15:0] scale_reg;
    logic [26:0] blocks_reg, blocks_next;

    // output stage: two slots, slot a shown first
    logic        a_valid_reg, b_valid_reg;
    out_word_t   a_reg, b_reg;

    logic        accept, pop;
    logic [4:0]  pos_eff;
    logic [26:0] blocks_eff;
    logic        active, data_byte;
    logic [31:0] w_lo, w_hi;

    assign in_ready  = ~b_valid_reg & (~a_valid_reg | out_ready);
    assign accept    = in_valid & in_ready;
    assign out_valid = a_valid_reg;
    assign out_data  = a_reg;
    assign pop       = a_valid_reg & out_ready;

    always_comb
    begin
        pos_eff    = in_data.start_of_tensor ? 5'd0 : pos_reg;
        blocks_eff = in_data.start_of_tensor ? 27'd0 : blocks_reg;
        // limit is weight_count / 32
        active     = {5'd0, blocks_eff} < weight_count_reg[31:5];
        data_byte  = active && pos_eff >= 5'd2;
        pos_next   = pos_eff;
        blocks_next = blocks_eff;
        if (active)
        begin
            if (pos_eff == 5'(BLOCK_BYTES - 1))
            begin
                pos_next    = 5'd0;
                blocks_next = blocks_eff + 27'd1;
            end
            else
            begin
                pos_next = pos_eff + 5'd1;
            end
        end
    end

    q4d_scale_mul u_mul_lo (.scale(scale_reg), .nibble(in_data.byte_value[3:0]), .weight_bits(w_lo));
    q4d_scale_mul u_mul_hi (.scale(scale_reg), .nibble(in_data.byte_value[7:4]), .weight_bits(w_hi));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_count_reg <= '0;
            pos_reg          <= '0;
            scale_lo_reg     <= '0;
            scale_reg        <= '0;
            blocks_reg       <= '0;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                weight_count_reg <= cfg_wdata;
            end
            if (accept)
            begin
                pos_reg    <= pos_next;
                blocks_reg <= blocks_next;
                if (active && pos_eff == 5'd0)
                begin
                    scale_lo_reg <= in_data.byte_value;
                end
                if (active && pos_eff == 5'd1)
                begin
                    scale_reg <= {in_data.byte_value, scale_lo_reg};
                end
            end
            // accept only when b empty and a empty or leaving
            if (accept && data_byte)
            begin
                a_valid_reg <= 1'b1;
                b_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                a_valid_reg <= b_valid_reg;
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && data_byte)
        begin
            a_reg <= '{weight_bits: w_lo, last_of_byte: 1'b0};
            b_reg <= '{weight_bits: w_hi, last_of_byte: 1'b1};
        end
        else if (pop)
        begin
            a_reg <= b_reg;
        end
    end

    // second slot never holds a word without the first
    assert property (@(posedge clk) disable iff (!rst_n) b_valid_reg |-> a_valid_reg)
        else $error("slot b valid without slot a");
    // a low-nibble weight is always followed by its high partner
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !a_reg.last_of_byte) |=> (a_valid_reg && a_reg.last_of_byte))
        else $error("high weight missing after low weight");
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg < 5'(BLOCK_BYTES))
        else $error("byte position out of range");

endmodule
